/* rtl/time_table_linear_interpolator_defines.svh */
// Assertion macros shared by the interpolator checker.
`ifndef TIME_TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH
`define TIME_TABLE_LINEAR_INTERPOLATOR_DEFINES_SVH

// Antecedent in this cycle, consequent in the next one.
`define TTI_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tti checker: next-cycle property failed");

// Antecedent and consequent in the same cycle.
`define TTI_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tti checker: same-cycle property failed");

`endif

/* rtl/tti_pkg.sv */
// Types and constants of the time table linear interpolator.
package tti_pkg;

	localparam int DEPTH     = 64;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int FRAC_W    = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 7;

	localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_VARYING = 1'd1;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic STATUS_OK        = 1'b0;
	localparam logic STATUS_NOT_FOUND = 1'b1;

	typedef struct packed {
		logic               command;
		logic [5:0]         entry_index;
		logic signed [31:0] time_point;
		logic signed [31:0] entry_value;
	} tti_in_t;

	typedef struct packed {
		logic signed [31:0] result_value;
		logic               status;
	} tti_out_t;

endpackage

/* rtl/time_table_linear_interpolator.sv */
// Time table linear interpolator: table store, search sequencer and interpolation.
// A write is answered without leaving idle; a constant-mode query passes ST_CONST;
// a time-varying query reads the last entry, scans one entry a cycle until it ends,
// and to interpolate runs the 16-step serial fraction divider, ST_MUL and ST_ADD.
// Throughput: one item at a time; during a query busy stays high until the result strobe.
// Reset: entry_count 1, time_varying 0, sequencer idle; table contents are kept.
module time_table_linear_interpolator import tti_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  tti_in_t              item,
	output logic                 done,
	output tti_out_t             result,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_CONST = 7'b0000010,
		ST_LAST  = 7'b0000100,
		ST_SCAN  = 7'b0001000,
		ST_DIV   = 7'b0010000,
		ST_MUL   = 7'b0100000,
		ST_ADD   = 7'b1000000
	} state_t;

	state_t state_q;

	logic [CNT_W-1:0] entry_count_q;
	logic             time_varying_q;
	logic             done_q;
	tti_out_t         result_q;

	logic signed [31:0] time_mem  [DEPTH];
	logic signed [31:0] value_mem [DEPTH];
	logic signed [31:0] t_rd_q;
	logic signed [31:0] v_rd_q;
	logic [IDX_W-1:0]   rd_addr;

	logic signed [31:0] qtime_q;
	logic               gt_last_q;
	logic signed [31:0] vlast_q;
	logic [IDX_W-1:0]   ptr_q;
	logic signed [31:0] tprev_q;
	logic signed [31:0] vprev_q;
	logic signed [31:0] v0_q;
	logic signed [32:0] diff_q;
	logic signed [49:0] prod_q;

	logic               accept;
	logic               wr_en;
	logic [CNT_W-1:0]   n_eff;
	logic [IDX_W-1:0]   last_idx;
	logic               t_lt;
	logic               t_eq;
	logic               brk;
	logic               div_load;
	logic               div_done;
	logic [FRAC_W-1:0]  frac;
	logic [31:0]        div_num;
	logic [31:0]        div_den;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign wr_en  = accept && (item.command == CMD_WRITE);

	always_comb begin
		if (entry_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (entry_count_q > CNT_W'(DEPTH)) begin
			n_eff = CNT_W'(DEPTH);
		end else begin
			n_eff = entry_count_q;
		end
	end
	assign last_idx = IDX_W'(n_eff - CNT_W'(1));

	// In ST_SCAN the read address runs one entry ahead of the data in t_rd_q / v_rd_q
	always_comb begin
		unique case (state_q)
			ST_IDLE: rd_addr = time_varying_q ? last_idx : '0;
			ST_LAST: rd_addr = '0;
			ST_SCAN: rd_addr = ptr_q + IDX_W'(1);
			default: rd_addr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			time_mem[item.entry_index]  <= item.time_point;
			value_mem[item.entry_index] <= item.entry_value;
		end
		t_rd_q <= time_mem[rd_addr];
		v_rd_q <= value_mem[rd_addr];
	end

	assign t_lt     = qtime_q < t_rd_q;
	assign t_eq     = qtime_q == t_rd_q;
	assign brk      = (ptr_q != '0) && (tprev_q < qtime_q) && (qtime_q < t_rd_q);
	assign div_load = (state_q == ST_SCAN) && !(ptr_q == '0) && brk;
	// both differences lie in 1 .. 2^32-1, so the low 32 bits are exact
	assign div_num  = 32'(qtime_q - tprev_q);
	assign div_den  = 32'(t_rd_q - tprev_q);

	tti_frac_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (div_load),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (frac)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			entry_count_q  <= CNT_W'(1);
			time_varying_q <= 1'b0;
			done_q         <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ENTRY_COUNT:  entry_count_q  <= cfg_data[CNT_W-1:0];
					REG_TIME_VARYING: time_varying_q <= cfg_data[0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (item.command == CMD_WRITE) begin
							done_q <= 1'b1;
						end else if (time_varying_q) begin
							state_q <= ST_LAST;
						end else begin
							state_q <= ST_CONST;
						end
					end
				end
				ST_CONST: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_LAST: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					priority if (ptr_q == '0 && t_lt) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (ptr_q == '0 && gt_last_q) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end else if (brk) begin
						state_q <= ST_DIV;
					end else if (t_eq || ptr_q == last_idx) begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers; status is cleared in idle and only set on a failed search
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				qtime_q  <= item.time_point;
				result_q <= '0;
			end
			ST_CONST: begin
				result_q.result_value <= v_rd_q;
				result_q.status       <= STATUS_OK;
			end
			ST_LAST: begin
				gt_last_q <= qtime_q > t_rd_q;
				vlast_q   <= v_rd_q;
				ptr_q     <= '0;
			end
			ST_SCAN: begin
				priority if (ptr_q == '0 && t_lt) begin
					result_q.result_value <= v_rd_q;
				end else if (ptr_q == '0 && gt_last_q) begin
					result_q.result_value <= vlast_q;
				end else if (brk) begin
					v0_q   <= vprev_q;
					diff_q <= $signed({v_rd_q[31], v_rd_q}) - $signed({vprev_q[31], vprev_q});
				end else if (t_eq) begin
					result_q.result_value <= v_rd_q;
				end else if (ptr_q == last_idx) begin
					result_q.result_value <= '0;
					result_q.status       <= STATUS_NOT_FOUND;
				end else begin
					ptr_q   <= ptr_q + IDX_W'(1);
					tprev_q <= t_rd_q;
					vprev_q <= v_rd_q;
				end
			end
			ST_DIV: ;
			ST_MUL: begin
				prod_q <= $signed({1'b0, frac}) * diff_q;
			end
			ST_ADD: begin
				// floor of frac * (v1 - v0) / 2^16, added to v0
				result_q.result_value <= v0_q + $signed(prod_q[47:16]);
				result_q.status       <= STATUS_OK;
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

/* rtl/tti_frac_div.sv */
// Bit-serial restoring divider giving the Q0.16 interpolation fraction.
module tti_frac_div import tti_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [31:0]       num,
	input  logic [31:0]       den,
	output logic              done,
	output logic [FRAC_W-1:0] quo
);

	localparam int STEP_W = $clog2(FRAC_W);

	logic [31:0]       rem_q;
	logic [31:0]       den_q;
	logic [FRAC_W-1:0] quo_q;
	logic [STEP_W-1:0] step_q;
	logic              run_q;
	logic              done_q;

	logic [32:0] shifted;
	logic [32:0] trial;
	logic        fits;

	// num < den always holds, so the remainder stays below den
	assign shifted = {rem_q, 1'b0};
	assign trial   = shifted - {1'b0, den_q};
	assign fits    = !trial[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				run_q  <= 1'b1;
				step_q <= '0;
			end else if (run_q) begin
				step_q <= step_q + STEP_W'(1);
				if (step_q == STEP_W'(FRAC_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rem_q <= num;
			den_q <= den;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= fits ? trial[31:0] : shifted[31:0];
			quo_q <= {quo_q[FRAC_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

/* rtl/tti_checker.sv */
// Port-level checker for the time table linear interpolator, with its bind.
`include "time_table_linear_interpolator_defines.svh"

module tti_checker import tti_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input tti_in_t  item,
	input logic     done,
	input tti_out_t result
);

	logic write_xfer;
	logic query_xfer;
	logic zero_ok;
	logic miss_seen;

	assign write_xfer = start && !busy && item.command == CMD_WRITE;
	assign query_xfer = start && !busy && item.command == CMD_QUERY;
	assign zero_ok    = done && result.result_value == 32'sd0 && result.status == STATUS_OK;
	assign miss_seen  = done && result.status == STATUS_NOT_FOUND;

	// a table write answers in the next cycle with a zero, ok result
	`TTI_ASSERT_NEXT(a_write_answer, write_xfer, zero_ok)

	// a taken query keeps the block busy, with no result, in the next cycle
	`TTI_ASSERT_NEXT(a_query_busy, query_xfer, busy && !done)

	// leaving the busy phase always delivers the result
	`TTI_ASSERT_SAME(a_busy_ends_done, $fell(busy), done)

	// a failed search reports a zero value
	`TTI_ASSERT_SAME(a_not_found_zero, miss_seen, result.result_value == 32'sd0)

endmodule

bind time_table_linear_interpolator tti_checker u_tti_checker (.*);

/* dv/tb_time_table_linear_interpolator.sv */
// Self-checking testbench for the time table linear interpolator: directed and random tables.
module tb_time_table_linear_interpolator;
	timeunit 1ns;
	timeprecision 1ps;

	import tti_pkg::*;

	localparam int ITEM_TARGET = 1100;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	tti_in_t              item      = '0;
	logic                 done;
	tti_out_t             result;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	time_table_linear_interpolator dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow of the table and registers
	logic signed [31:0] tab_time  [DEPTH];
	logic signed [31:0] tab_value [DEPTH];
	logic [CFG_W-1:0]   cur_count   = 7'd1;
	logic               cur_varying = 1'b0;

	tti_out_t awaited_results [$];
	int       items_sent  = 0;
	int       mismatches  = 0;
	bit       steady_run  = 1'b0;

	function automatic int span_of(logic [CFG_W-1:0] c);
		if (c == 0)
			return 1;
		if (c > DEPTH)
			return DEPTH;
		return int'(c);
	endfunction

	function automatic logic signed [31:0] lerp_value(int i, longint t);
		longint t0, t1, v0, v1, frac, acc;
		t0 = tab_time[i];
		t1 = tab_time[i + 1];
		v0 = tab_value[i];
		v1 = tab_value[i + 1];
		frac = ((t - t0) <<< 16) / (t1 - t0);
		acc = v0 * 65536 + frac * (v1 - v0);
		// arithmetic shift floors
		return 32'(acc >>> 16);
	endfunction

	function automatic tti_out_t predict_result(tti_in_t it);
		tti_out_t r;
		int       n;
		longint   t;
		bit       hit;
		r = '0;
		r.status = STATUS_OK;
		if (it.command == CMD_WRITE) begin
			tab_time[it.entry_index]  = it.time_point;
			tab_value[it.entry_index] = it.entry_value;
		end else if (!cur_varying) begin
			r.result_value = tab_value[0];
		end else begin
			n = span_of(cur_count);
			t = it.time_point;
			if (t < tab_time[0]) begin
				r.result_value = tab_value[0];
			end else if (t > tab_time[n - 1]) begin
				r.result_value = tab_value[n - 1];
			end else begin
				hit = 1'b0;
				for (int i = 0; i < n && !hit; i++) begin
					if (t == tab_time[i]) begin
						r.result_value = tab_value[i];
						hit = 1'b1;
					end else if (i + 1 < n && tab_time[i] < t && t < tab_time[i + 1]) begin
						r.result_value = lerp_value(i, t);
						hit = 1'b1;
					end
				end
				if (!hit)
					r.status = STATUS_NOT_FOUND;
			end
		end
		return r;
	endfunction

	function automatic void flag_mismatch(string what, longint want_v, longint got_v);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
	endfunction

	always @(posedge clk) begin : check_results
		tti_out_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				flag_mismatch("result with nothing pending, value", 0, result.result_value);
			end else begin
				want = awaited_results.pop_front();
				if (result.result_value !== want.result_value)
					flag_mismatch("result_value", want.result_value, result.result_value);
				if (result.status !== want.status)
					flag_mismatch("status", want.status, result.status);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if ($urandom_range(0, 39) == 0)
			steady_run = !steady_run;
		if (steady_run)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 92)
			return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	task automatic send_item(tti_in_t it);
		int gap;
		start <= 1'b1;
		item  <= it;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		awaited_results.push_back(predict_result(it));
		items_sent++;
		gap = pick_gap();
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_entry(logic [5:0] idx, logic signed [31:0] t, logic signed [31:0] v);
		tti_in_t w;
		w.command     = CMD_WRITE;
		w.entry_index = idx;
		w.time_point  = t;
		w.entry_value = v;
		send_item(w);
	endtask

	task automatic query_at(logic signed [31:0] t);
		tti_in_t q;
		q.command     = CMD_QUERY;
		q.entry_index = 6'($urandom);
		q.time_point  = t;
		q.entry_value = $urandom;
		send_item(q);
	endtask

	// hold the sender until every outstanding transfer has come back
	task automatic wait_drain();
		start <= 1'b0;
		while (awaited_results.size() != 0 || busy)
			@(posedge clk);
		@(posedge clk);
	endtask

	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ENTRY_COUNT)
			cur_count = data;
		else
			cur_varying = data[0];
		@(posedge clk);
	endtask

	function automatic logic signed [31:0] rand_value();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFFFFFF;
			1: return 32'sh80000000;
			2, 3, 4: return $signed($urandom_range(0, 4000)) - 2000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [31:0] pick_query_time(int n);
		int       i;
		longint   lo, hi;
		bit [63:0] r64;
		i = $urandom_range(0, n - 1);
		r64 = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0, 1: return tab_time[i];
			2, 3, 4, 5: begin
				if (i + 1 < n) begin
					lo = tab_time[i];
					hi = tab_time[i + 1];
					if (hi - lo > 1)
						return 32'(lo + 1 + longint'(r64 % 64'(hi - lo - 1)));
				end
				return tab_time[i];
			end
			6: return tab_time[0] - 1;
			7: return tab_time[n - 1] + 1;
			8: return $urandom;
			default: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
		endcase
	endfunction

	// shapes: wide sorted, narrow ascending, with repeats, or unsorted
	task automatic load_table(int n, int shape);
		int stamps [$];
		int base;
		base = int'($urandom) >>> 2;
		for (int i = 0; i < n; i++) begin
			if (shape <= 3 || shape == 9) begin
				stamps.push_back(int'($urandom));
			end else begin
				base += (shape <= 6) ? $urandom_range(1, 50) : $urandom_range(0, 3);
				stamps.push_back(base);
			end
		end
		if (shape <= 3)
			stamps.sort();
		for (int i = 0; i < n; i++)
			write_entry(6'(i), stamps[i], rand_value());
	endtask

	// reset defaults: one entry, constant value
	task automatic test_constant_mode();
		write_entry(6'd0, 32'sh80000000, 32'sh7FFFFFFF);
		query_at(32'sh7FFFFFFF);
		write_entry(6'd63, 32'sh7FFFFFFF, 32'sh80000000);
		write_entry(6'd0, 32'sh7FFFFFFF, 32'sh80000000);
		query_at(32'sh80000000);
		query_at(32'sd0);
	endtask

	task automatic test_interpolation_directed();
		wait_drain();
		cfg_write(REG_ENTRY_COUNT, 7'd4);
		cfg_write(REG_TIME_VARYING, 7'd1);
		write_entry(6'd0, -32'sd1000, 32'sh80000000);
		write_entry(6'd1, 32'sd0, 32'sh7FFFFFFF);
		write_entry(6'd2, 32'sd7, -32'sd3);
		write_entry(6'd3, 32'sd1000, 32'sh00010000);
		query_at(32'sh80000000);
		query_at(32'sh7FFFFFFF);
		query_at(-32'sd1000);
		query_at(32'sd7);
		query_at(32'sd1000);
		query_at(-32'sd1);
		query_at(32'sd3);
		query_at(32'sd500);
		query_at(32'sd1);
		// widest possible span
		write_entry(6'd0, 32'sh80000000, 32'sh80000000);
		write_entry(6'd3, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
		query_at(32'sh80000000);
		query_at(32'sh7FFFFFFE);
		query_at(-32'sd1);
	endtask

	task automatic test_random_tables();
		logic [CFG_W-1:0] count_sweep [6] = '{7'd0, 7'd127, 7'd64, 7'd65, 7'd1, 7'd2};
		logic [CFG_W-1:0] cnt;
		logic             varying;
		int               phase;
		int               n;
		int               quota;
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			wait_drain();
			if (phase < 6)
				cnt = count_sweep[phase];
			else if ($urandom_range(0, 3) == 0)
				cnt = 7'($urandom_range(0, 127));
			else
				cnt = 7'($urandom_range(2, 16));
			if (phase < 6)
				varying = 1'b1;
			else if (phase == 6)
				varying = 1'b0;
			else
				varying = ($urandom_range(0, 4) != 0);
			cfg_write(REG_ENTRY_COUNT, cnt);
			cfg_write(REG_TIME_VARYING, {6'd0, varying});
			n = span_of(cnt);
			load_table(n, $urandom_range(0, 9));
			quota = $urandom_range(20, 60);
			repeat (quota) begin
				if ($urandom_range(0, 59) == 0)
					wait_drain();
				if ($urandom_range(0, 9) == 0)
					write_entry(6'($urandom), $urandom, rand_value());
				else
					query_at(pick_query_time(n));
			end
			phase++;
		end
	endtask

	initial begin
		int guard;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_constant_mode();
		test_interpolation_directed();
		test_random_tables();
		start <= 1'b0;
		guard = 0;
		while (awaited_results.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (100) @(posedge clk);
		mismatches += awaited_results.size();
		if (mismatches == 0)
			$display("tb_time_table_linear_interpolator: done, clean");
		else
			$display("tb_time_table_linear_interpolator: done, errors");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("tb_time_table_linear_interpolator: done, errors");
		$finish;
	end

endmodule
